FILE: rtl/ptf_pkg.sv
package ptf_pkg;

  // Fixed field widths of the channels
  localparam int unsigned ACTION_W = 1;
  localparam int unsigned INDEX_W  = 12;
  localparam int unsigned PVAL_W   = 24;
  localparam int unsigned NUMBER_W = 31;
  localparam int unsigned EXP_W    = 5;
  localparam int unsigned COUNT_W  = 13;

  // Defaults of the top-level parameters
  localparam int unsigned TABLE_DEPTH_DEF = 4096;
  localparam int unsigned PRIME_BITS_DEF  = 24;

  // Results per factor item are capped
  localparam int unsigned MAX_RESULTS = 9;
  localparam int unsigned RES_CNT_W   = 4;

  // Input action codes
  localparam logic [ACTION_W-1:0] ACT_LOAD   = 1'b0;
  localparam logic [ACTION_W-1:0] ACT_FACTOR = 1'b1;

  // Configuration register indexes
  localparam logic [0:0] REG_PRIMES_IN_USE = 1'b0;

  // One classified item from the front queue to the engine
  typedef struct packed {
    logic                is_load;
    logic                in_range;
    logic [INDEX_W-1:0]  table_index;
    logic [PVAL_W-1:0]   prime_value;
    logic [NUMBER_W-1:0] number;
  } item_t;

  // Engine states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CHECK,
    ST_START,
    ST_DIV,
    ST_PUSH,
    ST_DONE
  } eng_state_t;

endpackage

FILE: rtl/ptf_in_if.sv
interface ptf_in_if
  import ptf_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [INDEX_W-1:0]  table_index;
  logic [PVAL_W-1:0]   prime_value;
  logic [NUMBER_W-1:0] number;

  modport source (output valid, action, table_index, prime_value, number, input ready);
  modport sink (input valid, action, table_index, prime_value, number, output ready);
endinterface

FILE: rtl/ptf_out_if.sv
interface ptf_out_if
  import ptf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [PVAL_W-1:0] prime_factor;
  logic [EXP_W-1:0]  exponent;
  logic              none_found;
  logic              last;

  modport source (output valid, prime_factor, exponent, none_found, last, input ready);
  modport sink (input valid, prime_factor, exponent, none_found, last, output ready);
endinterface

FILE: rtl/ptf_front.sv
module ptf_front
  import ptf_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ptf_in_if.sink     in_bus,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_pop
);

  // Two-entry queue between the input channel and the engine
  item_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;
  item_t      item_in;

  // Classify the incoming beat
  always_comb begin
    item_in.is_load     = (in_bus.action == ACT_LOAD);
    item_in.in_range    = (32'(in_bus.table_index) < TABLE_DEPTH);
    item_in.table_index = in_bus.table_index;
    item_in.prime_value = in_bus.prime_value;
    item_in.number      = in_bus.number;
  end

  assign in_bus.ready = (cnt_r != 2'd2);
  assign push    = in_bus.valid && in_bus.ready;
  assign pop     = q_pop && q_valid;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

FILE: rtl/ptf_div.sv
module ptf_div
  import ptf_pkg::*;
#(
  parameter int unsigned PRIME_BITS = PRIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [NUMBER_W-1:0]   dividend,
  input  logic [PRIME_BITS-1:0] divisor,
  output logic                  done,
  output logic [NUMBER_W-1:0]   quotient,
  output logic                  rem_zero
);

  localparam int unsigned STEP_W = $clog2(NUMBER_W + 1);

  // Restoring divider, one quotient bit per cycle
  logic [NUMBER_W-1:0]   q_r, q_nxt;
  logic [PRIME_BITS:0]   rem_r, rem_nxt;
  logic [PRIME_BITS-1:0] dsr_r;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [PRIME_BITS+1:0] shifted;
  logic [PRIME_BITS+1:0] diff;

  always_comb begin
    shifted  = {rem_r, q_r[NUMBER_W-1]};
    diff     = shifted - {2'b00, dsr_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (diff[PRIME_BITS+1]) begin
        rem_nxt = shifted[PRIME_BITS:0];
        q_nxt   = {q_r[NUMBER_W-2:0], 1'b0};
      end else begin
        rem_nxt = diff[PRIME_BITS:0];
        q_nxt   = {q_r[NUMBER_W-2:0], 1'b1};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(NUMBER_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;
  assign rem_zero = (rem_r == '0);

endmodule

FILE: rtl/ptf_back.sv
module ptf_back
  import ptf_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned PRIME_BITS  = PRIME_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [COUNT_W-1:0] primes_in_use,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               q_pop,
  ptf_out_if.source          out_bus
);

  localparam int unsigned AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  // Prime table storage
  logic [PRIME_BITS-1:0] table_mem [TABLE_DEPTH];
  logic [PRIME_BITS-1:0] rd_data_r;
  logic                  rd_en;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [PRIME_BITS-1:0] wr_data;
  logic [31:0]           idx32;
  logic [31:0]           pval32;
  logic [31:0]           lim32;

  eng_state_t state_r, state_nxt;

  logic [NUMBER_W-1:0]   rest_r, rest_nxt;
  logic [PRIME_BITS-1:0] p_r, p_nxt;
  logic [EXP_W-1:0]      e_r, e_nxt;
  logic [CNT_W-1:0]      i_r, i_nxt;
  logic [CNT_W-1:0]      lim_r, lim_nxt;
  logic [RES_CNT_W-1:0]  k_r, k_nxt;
  logic                  pend_v_r, pend_v_nxt;
  logic [PRIME_BITS-1:0] pend_p_r, pend_p_nxt;
  logic [EXP_W-1:0]      pend_e_r, pend_e_nxt;

  logic                  out_v_r, out_v_nxt;
  logic [PVAL_W-1:0]     out_p_r, out_p_nxt;
  logic [EXP_W-1:0]      out_e_r, out_e_nxt;
  logic                  out_n_r, out_n_nxt;
  logic                  out_l_r, out_l_nxt;

  logic                  div_start;
  logic                  div_done;
  logic [NUMBER_W-1:0]   div_quo;
  logic                  div_rz;
  logic                  slot_free;
  logic                  rd_small;
  logic                  rd_big;
  logic [31:0]           pend32;

  assign slot_free = !out_v_r || out_bus.ready;
  assign idx32     = 32'(q_item.table_index);
  assign pval32    = 32'(q_item.prime_value);
  assign wr_addr   = idx32[AW-1:0];
  assign wr_data   = pval32[PRIME_BITS-1:0];
  assign lim32     = (32'(primes_in_use) > TABLE_DEPTH) ? TABLE_DEPTH : 32'(primes_in_use);
  assign rd_small  = (32'(rd_data_r) < 32'd2);
  assign rd_big    = (32'(rd_data_r) > 32'(rest_r));
  assign pend32    = 32'(pend_p_r);

  ptf_div #(
    .PRIME_BITS (PRIME_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rest_r),
    .divisor  (p_r),
    .done     (div_done),
    .quotient (div_quo),
    .rem_zero (div_rz)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && !q_item.is_load) begin
          state_nxt = (q_item.number == '0) ? ST_DONE : ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (i_r >= lim_r || k_r == RES_CNT_W'(MAX_RESULTS)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (rd_small) begin
          state_nxt = ST_FETCH;
        end else if (rd_big) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_START;
        end
      end
      ST_START: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          if (div_rz) begin
            state_nxt = ST_START;
          end else if (e_r != '0) begin
            state_nxt = ST_PUSH;
          end else begin
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_PUSH: begin
        if (slot_free || !pend_v_r) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    rest_nxt   = rest_r;
    p_nxt      = p_r;
    e_nxt      = e_r;
    i_nxt      = i_r;
    lim_nxt    = lim_r;
    k_nxt      = k_r;
    pend_v_nxt = pend_v_r;
    pend_p_nxt = pend_p_r;
    pend_e_nxt = pend_e_r;
    out_v_nxt  = out_v_r && !out_bus.ready;
    out_p_nxt  = out_p_r;
    out_e_nxt  = out_e_r;
    out_n_nxt  = out_n_r;
    out_l_nxt  = out_l_r;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    div_start  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        q_pop = 1'b1;
        if (q_valid) begin
          wr_en      = q_item.is_load && q_item.in_range;
          rest_nxt   = q_item.number;
          i_nxt      = '0;
          k_nxt      = '0;
          pend_v_nxt = 1'b0;
          lim_nxt    = lim32[CNT_W-1:0];
        end
      end
      ST_FETCH: begin
        rd_en = 1'b1;
      end
      ST_CHECK: begin
        p_nxt = rd_data_r;
        e_nxt = '0;
        if (rd_small) begin
          i_nxt = i_r + 1'b1;
        end
      end
      ST_START: begin
        div_start = 1'b1;
      end
      ST_DIV: begin
        if (div_done) begin
          if (div_rz) begin
            rest_nxt = div_quo;
            e_nxt    = e_r + 1'b1;
          end else if (e_r == '0) begin
            i_nxt = i_r + 1'b1;
          end
        end
      end
      ST_PUSH: begin
        if (slot_free || !pend_v_r) begin
          if (pend_v_r) begin
            out_v_nxt = 1'b1;
            out_p_nxt = pend32[PVAL_W-1:0];
            out_e_nxt = pend_e_r;
            out_n_nxt = 1'b0;
            out_l_nxt = 1'b0;
          end
          pend_v_nxt = 1'b1;
          pend_p_nxt = p_r;
          pend_e_nxt = e_r;
          k_nxt      = k_r + 1'b1;
          i_nxt      = i_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_v_nxt = 1'b1;
          out_l_nxt = 1'b1;
          if (pend_v_r) begin
            out_p_nxt = pend32[PVAL_W-1:0];
            out_e_nxt = pend_e_r;
            out_n_nxt = 1'b0;
          end else begin
            out_p_nxt = '0;
            out_e_nxt = '0;
            out_n_nxt = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      out_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      out_v_r  <= out_v_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rest_r   <= rest_nxt;
    p_r      <= p_nxt;
    e_r      <= e_nxt;
    i_r      <= i_nxt;
    lim_r    <= lim_nxt;
    k_r      <= k_nxt;
    pend_p_r <= pend_p_nxt;
    pend_e_r <= pend_e_nxt;
    out_p_r  <= out_p_nxt;
    out_e_r  <= out_e_nxt;
    out_n_r  <= out_n_nxt;
    out_l_r  <= out_l_nxt;
  end

  // Table write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= table_mem[i_r[AW-1:0]];
    end
  end

  assign out_bus.valid        = out_v_r;
  assign out_bus.prime_factor = out_p_r;
  assign out_bus.exponent     = out_e_r;
  assign out_bus.none_found   = out_n_r;
  assign out_bus.last         = out_l_r;

endmodule

FILE: rtl/prime_table_trial_factorizer.sv
// Channel  | Dir | Beat contents
// in_bus   | in  | action, table_index, prime_value, number
// out_bus  | out | prime_factor, exponent, none_found, last
// APB      | in  | primes_in_use at byte address 0
//
// A load beat is written to the table in the idle state. A factor beat walks
// the table: a fetch and a check state per entry tried, a start state and
// the one-bit-a-cycle divider per division, a push state per factor found,
// and the idle and done states to start and finish.
// Reset is synchronous and active low; the table holds no reset value.
// A two-beat queue keeps in_bus ready until it holds two beats; the engine
// stalls on a full output register only when it has a beat to hand over.
module prime_table_trial_factorizer
  import ptf_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned PRIME_BITS  = PRIME_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  ptf_in_if.sink       in_bus,
  ptf_out_if.source    out_bus,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [0:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [COUNT_W-1:0] primes_in_use_r;
  logic               q_valid;
  item_t              q_item;
  logic               q_pop;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == REG_PRIMES_IN_USE) ? 32'(primes_in_use_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primes_in_use_r <= '0;
    end else if (psel && penable && pwrite && paddr == REG_PRIMES_IN_USE) begin
      primes_in_use_r <= pwdata[COUNT_W-1:0];
    end
  end

  ptf_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  ptf_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PRIME_BITS  (PRIME_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .primes_in_use (primes_in_use_r),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_bus       (out_bus)
  );

`ifndef SYNTHESIS
  // A none-found beat is always the only and final beat of its item
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.none_found |-> out_bus.last && out_bus.exponent == '0
      && out_bus.prime_factor == '0)
    else $error("none-found beat malformed");

  // A reported factor always divides at least once
  a_factor_exp: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && !out_bus.none_found |-> out_bus.exponent != '0)
    else $error("factor beat with zero exponent");

  // No result is shown right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_bus.valid)
    else $error("result valid after reset");
`endif

endmodule

FILE: tb/prime_table_trial_factorizer_tb.sv
`timescale 1ns / 1ps

module prime_table_trial_factorizer_tb;
  import ptf_pkg::*;

  localparam int unsigned DEPTH      = TABLE_DEPTH_DEF;
  localparam int unsigned FILL       = 128;
  localparam int unsigned CYCLE_CAP  = 3000000;
  localparam int unsigned DRAIN_WAIT = 100;

  // One input beat as the testbench keeps it.
  typedef struct {
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  table_index;
    logic [PVAL_W-1:0]   prime_value;
    logic [NUMBER_W-1:0] number;
  } beat_t;

  // One result beat as the testbench expects it.
  typedef struct {
    logic [PVAL_W-1:0] prime_factor;
    logic [EXP_W-1:0]  exponent;
    logic              none_found;
    logic              last;
  } factor_res_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [0:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  ptf_in_if  in_bus ();
  ptf_out_if out_bus ();

  prime_table_trial_factorizer i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow state of the block.
  logic [PVAL_W-1:0]  shadow_table [DEPTH];
  logic [COUNT_W-1:0] shadow_count;

  beat_t       pending_beats [$];
  factor_res_t factor_results [$];

  bit          calm;
  int unsigned errors;
  int unsigned n_loads;
  int unsigned n_factors;
  int unsigned n_results;
  int unsigned cycles;
  int unsigned in_gap;
  int unsigned out_stall;
  int unsigned first_primes [DEPTH];

  // Work out the results of one accepted beat.
  task automatic predict_factors(input beat_t b);
    logic [NUMBER_W-1:0] rest;
    logic [PVAL_W-1:0]   p;
    factor_res_t         r;
    int unsigned         lim;
    int unsigned         k;
    int unsigned         e;
    if (b.action == ACT_LOAD) begin
      shadow_table[b.table_index] = b.prime_value;
      n_loads++;
      return;
    end
    n_factors++;
    lim = (shadow_count > DEPTH) ? DEPTH : shadow_count;
    rest = b.number;
    k = 0;
    if (rest != 0) begin
      for (int i = 0; i < lim && k < MAX_RESULTS; i++) begin
        p = shadow_table[i];
        if (p < 2) continue;
        if (p > rest) break;
        e = 0;
        while (rest % p == 0) begin
          rest = rest / p;
          e++;
        end
        if (e != 0) begin
          r.prime_factor = p;
          r.exponent = e[EXP_W-1:0];
          r.none_found = 1'b0;
          r.last = 1'b0;
          factor_results = {factor_results, r};
          k++;
        end
      end
    end
    if (k == 0) begin
      r.prime_factor = '0;
      r.exponent = '0;
      r.none_found = 1'b1;
      r.last = 1'b1;
      factor_results = {factor_results, r};
    end else begin
      factor_results[factor_results.size()-1].last = 1'b1;
    end
  endtask

  function automatic int unsigned draw_wait();
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Input driver: presents queued beats and predicts on each accepted beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        predict_factors('{in_bus.action, in_bus.table_index, in_bus.prime_value,
                          in_bus.number});
        in_gap = draw_wait();
      end
      if (!(in_bus.valid && !in_bus.ready)) begin
        if (in_gap > 0) begin
          in_gap = in_gap - 1;
          in_bus.valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          beat_t b;
          b = pending_beats.pop_front();
          in_bus.action <= b.action;
          in_bus.table_index <= b.table_index;
          in_bus.prime_value <= b.prime_value;
          in_bus.number <= b.number;
          in_bus.valid <= 1'b1;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each beat with the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        n_results++;
        if (factor_results.size() == 0) begin
          $error("unexpected result beat: prime_factor %0d", out_bus.prime_factor);
          errors++;
        end else begin
          factor_res_t x;
          x = factor_results.pop_front();
          if (out_bus.prime_factor !== x.prime_factor) begin
            $error("prime_factor expected %0d actual %0d", x.prime_factor,
                   out_bus.prime_factor);
            errors++;
          end
          if (out_bus.exponent !== x.exponent) begin
            $error("exponent expected %0d actual %0d", x.exponent, out_bus.exponent);
            errors++;
          end
          if (out_bus.none_found !== x.none_found) begin
            $error("none_found expected %0d actual %0d", x.none_found,
                   out_bus.none_found);
            errors++;
          end
          if (out_bus.last !== x.last) begin
            $error("last expected %0d actual %0d", x.last, out_bus.last);
            errors++;
          end
        end
        out_stall = draw_wait();
      end
      if (out_stall > 0) begin
        out_stall = out_stall - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Register write over the configuration port.
  task automatic write_count(input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_PRIMES_IN_USE;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    shadow_count = value[COUNT_W-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Wait until all beats are sent and every result has come back.
  task automatic drain();
    while (pending_beats.size() > 0 || in_bus.valid || factor_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic queue_load(input int unsigned idx, input logic [PVAL_W-1:0] value);
    beat_t b;
    b.action = ACT_LOAD;
    b.table_index = idx[INDEX_W-1:0];
    b.prime_value = value;
    b.number = NUMBER_W'($urandom());
    pending_beats = {pending_beats, b};
  endtask

  task automatic queue_factor(input logic [NUMBER_W-1:0] value);
    beat_t b;
    b.action = ACT_FACTOR;
    b.table_index = INDEX_W'($urandom());
    b.prime_value = PVAL_W'($urandom());
    b.number = value;
    pending_beats = {pending_beats, b};
  endtask

  // Random number for a factor beat: in half the draws a smooth product of table primes.
  function automatic logic [NUMBER_W-1:0] pick_number();
    longint unsigned n;
    longint unsigned p;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      n = 1;
      repeat ($urandom_range(1, 8)) begin
        p = first_primes[$urandom_range(0, 15)];
        if (n * p < 64'h8000_0000) n = n * p;
      end
      return n[NUMBER_W-1:0];
    end else if (sel < 8) begin
      return NUMBER_W'($urandom_range(1, 5000));
    end
    return NUMBER_W'($urandom_range(1, 32'h7FFF_FFFF));
  endfunction

  // Stimulus.
  initial begin
    bit composite [40000];
    int unsigned found;
    int unsigned odd_table [12];
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_bus.valid = 1'b0;
    in_bus.action = ACT_LOAD;
    in_bus.table_index = '0;
    in_bus.prime_value = '0;
    in_bus.number = '0;
    out_bus.ready = 1'b0;
    errors = 0;
    n_loads = 0;
    n_factors = 0;
    n_results = 0;
    cycles = 0;
    shadow_count = '0;
    calm = 0;
    odd_table = '{0, 1, 4, 2, 3, 5, 7, 11, 13, 17, 19, 23};

    // Sieve for the first table-full of primes.
    found = 0;
    for (int i = 2; i < 40000 && found < DEPTH; i++) begin
      if (!composite[i]) begin
        first_primes[found] = i;
        found++;
        for (int j = i * i; j < 40000; j += i) composite[j] = 1;
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Fill the low part of the table; no walk reads past it.
    for (int i = 0; i < FILL; i++) queue_load(i, PVAL_W'(first_primes[i]));
    drain();

    // Directed: every loaded entry in use.
    write_count(FILL);
    queue_factor(1);
    queue_factor(0);
    queue_factor(31'h4000_0000);
    queue_factor(223092870);
    queue_factor(NUMBER_W'(first_primes[FILL-1] * first_primes[FILL-1]));
    queue_factor(31'h7FFF_FFFF);
    queue_factor(97);
    drain();

    // Count above the table depth is clamped; these walks stop early.
    write_count(13'h1FFF);
    queue_factor(1000);
    queue_factor(65536);
    drain();

    // No entries in use, then a single one.
    write_count(0);
    queue_factor(12);
    queue_factor(31'h7FFF_FFFF);
    drain();
    write_count(1);
    queue_factor(6);
    queue_factor(31'h4000_0000);
    queue_factor(9);
    drain();

    // Skipped zero and one entries, a composite entry and the result cap.
    for (int i = 0; i < 12; i++) queue_load(i, PVAL_W'(odd_table[i]));
    drain();
    write_count(12);
    queue_factor(892371480);
    queue_factor(16);
    queue_factor(7);
    drain();
    for (int i = 0; i < 12; i++) queue_load(i, PVAL_W'(first_primes[i]));
    queue_load(DEPTH - 1, 24'hFFFFFF);
    drain();

    // Random phases with small counts; loads go to the top of the table.
    for (int ph = 0; ph < 8; ph++) begin
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: write_count($urandom_range(0, 1));
        1: write_count($urandom_range(2, 9));
        2: write_count($urandom_range(10, 40));
        default: write_count(64);
      endcase
      repeat (32) begin
        if ($urandom_range(0, 6) == 0)
          queue_load($urandom_range(3584, DEPTH - 1), PVAL_W'($urandom()));
        else
          queue_factor(pick_number());
      end
      drain();
    end

    // A few walks with every loaded entry in use.
    calm = 0;
    write_count(FILL);
    queue_factor(NUMBER_W'($urandom_range(1, 2000)));
    queue_factor(NUMBER_W'($urandom_range(1, 32'h7FFF_FFFF)));
    queue_factor(pick_number());
    drain();

    $display("Ran %0d table loads and %0d factor beats, checked %0d result beats.",
             n_loads, n_factors, n_results);
    $display("Counts covered zero, one, small, every loaded entry and a clamped value.");
    if (errors == 0 && factor_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
